// File: rtl/msm_pkg.sv
`default_nettype none

package msm_pkg;

    // fixed port field widths
    localparam int CH_W  = 8;
    localparam int LEN_W = 8;
    localparam int SMP_W = 16;

    // control word from the sequencer to the shared compare unit
    typedef struct packed {
        logic load;   // take a new candidate, clear the counts
        logic acc;    // compare read data against the candidate
    } t_cmp_ctl;

endpackage

`default_nettype wire

// File: rtl/msm_in_if.sv
`default_nettype none

interface msm_in_if import msm_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [CH_W-1:0]         channel;
    logic [LEN_W-1:0]        window_len;
    logic signed [SMP_W-1:0] sample;

    modport source (output valid, output channel, output window_len, output sample,
                    input ready);
    modport sink   (input valid, input channel, input window_len, input sample,
                    output ready);
endinterface

`default_nettype wire

// File: rtl/msm_out_if.sv
`default_nettype none

interface msm_out_if import msm_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [SMP_W-1:0] median;
    logic                    rejected;

    modport source (output valid, output median, output rejected, input ready);
    modport sink   (input valid, input median, input rejected, output ready);
endinterface

`default_nettype wire

// File: rtl/msm_store.sv
`default_nettype none

module msm_store #(
    parameter int DEPTH = 128,
    parameter int AW    = 7,
    parameter int CHN   = 8,
    parameter int CW    = 3,
    parameter int IW    = 4,
    parameter int SB    = 16
) (
    input  logic                 i_clk,
    // sample memory, one row of WINDOW_MAX entries per channel
    input  logic                 i_we,
    input  logic [AW-1:0]        i_waddr,
    input  logic signed [SB-1:0] i_wdata,
    input  logic                 i_re,
    input  logic [AW-1:0]        i_raddr,
    output logic signed [SB-1:0] o_rdata,
    // write position memory, one entry per channel
    input  logic                 i_pos_we,
    input  logic [CW-1:0]        i_pos_waddr,
    input  logic [IW-1:0]        i_pos_wdata,
    input  logic                 i_pos_re,
    input  logic [CW-1:0]        i_pos_raddr,
    output logic [IW-1:0]        o_pos_rdata
);

    logic signed [SB-1:0] r_mem [DEPTH];
    logic signed [SB-1:0] r_rdata;
    logic [IW-1:0]        r_pos_mem [CHN];
    logic [IW-1:0]        r_pos_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_pos_we) begin
            r_pos_mem[i_pos_waddr] <= i_pos_wdata;
        end
        if (i_pos_re) begin
            r_pos_rdata <= r_pos_mem[i_pos_raddr];
        end
    end

    assign o_rdata     = r_rdata;
    assign o_pos_rdata = r_pos_rdata;

endmodule

`default_nettype wire

// File: rtl/msm_cmp.sv
`default_nettype none

// Rank counter: holds one candidate and counts how many window entries
// are below it and equal to it. The candidate is the median when its
// rank range covers k = len/2.
module msm_cmp import msm_pkg::*; #(
    parameter int SB = 16,
    parameter int IW = 4
) (
    input  logic                 i_clk,
    input  t_cmp_ctl             i_ctl,
    input  logic signed [SB-1:0] i_data,
    input  logic [IW-1:0]        i_k,
    output logic signed [SB-1:0] o_cand,
    output logic                 o_hit
);

    logic signed [SB-1:0] r_cand;
    logic [IW-1:0]        r_lt;
    logic [IW-1:0]        r_eq;
    logic [IW:0]          le_sum;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_cand <= i_data;
            r_lt   <= '0;
            r_eq   <= '0;
        end else if (i_ctl.acc) begin
            if (i_data < r_cand) begin
                r_lt <= r_lt + 1'b1;
            end
            if (i_data == r_cand) begin
                r_eq <= r_eq + 1'b1;
            end
        end
    end

    assign le_sum = {1'b0, r_lt} + {1'b0, r_eq};
    assign o_hit  = (r_lt <= i_k) && ({1'b0, i_k} < le_sum);
    assign o_cand = r_cand;

endmodule

`default_nettype wire

// File: rtl/multichannel_sliding_median.sv
`default_nettype none

// channel  dir  payload                               handshake
// i_in     in   channel[8], window_len[8], sample[16]  valid/ready
// o_out    out  median[16], rejected[1]                valid/ready
//
// After reset the sample and position memories are cleared, one entry a
// cycle, with i_in.ready low until all CHANNELS*WINDOW_MAX entries are written.
// A rejected word goes from S_IDLE straight to S_FIN. A valid word passes
// S_POS, then S_CRD, S_CLD, S_SCAN and S_CHK for each window entry tried
// as candidate in order, until one hits, then S_FIN. The single compare unit
// and the one sample memory read port compare one window entry per cycle.
// One word is in work at a time; the result register may still hold the
// previous result while a new word is taken, and the block waits at the end
// of a word while o_out is stalled.
module multichannel_sliding_median import msm_pkg::*; #(
    parameter int CHANNELS    = 8,
    parameter int WINDOW_MAX  = 16,
    parameter int SAMPLE_BITS = 16
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    msm_in_if.sink   i_in,
    msm_out_if.source o_out
);

    localparam int DEPTH = CHANNELS * WINDOW_MAX;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int IW    = $clog2(WINDOW_MAX);
    localparam int SB    = SAMPLE_BITS;

    localparam logic [AW-1:0]    CLR_LAST = AW'(DEPTH - 1);
    localparam logic [AW-1:0]    WMAX_A   = AW'(WINDOW_MAX);
    localparam logic [AW:0]      CHN_A    = (AW + 1)'(CHANNELS);
    localparam logic [CH_W:0]    CH_LIM   = (CH_W + 1)'(CHANNELS);
    localparam logic [LEN_W:0]   LEN_LIM  = (LEN_W + 1)'(WINDOW_MAX);

    localparam logic [2:0] S_CLR  = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_POS  = 3'd2;
    localparam logic [2:0] S_CRD  = 3'd3;
    localparam logic [2:0] S_CLD  = 3'd4;
    localparam logic [2:0] S_SCAN = 3'd5;
    localparam logic [2:0] S_CHK  = 3'd6;
    localparam logic [2:0] S_FIN  = 3'd7;

    logic [2:0]              r_state, n_state;
    logic [AW-1:0]           r_clr, n_clr;
    logic [AW-1:0]           r_base, n_base;
    logic [CW-1:0]           r_ch, n_ch;
    logic [IW-1:0]           r_len, n_len;
    logic signed [SB-1:0]    r_smp, n_smp;
    logic [IW-1:0]           r_i, n_i;
    logic [IW-1:0]           r_j, n_j;
    logic signed [SMP_W-1:0] r_med, n_med;
    logic                    r_rej, n_rej;
    logic                    r_ov, n_ov;
    logic signed [SMP_W-1:0] r_om, n_om;
    logic                    r_or, n_or;

    logic                    mem_we, mem_re;
    logic [AW-1:0]           mem_waddr, mem_raddr;
    logic signed [SB-1:0]    mem_wdata, mem_rdata;
    logic                    pos_we, pos_re;
    logic [CW-1:0]           pos_waddr, pos_raddr;
    logic [IW-1:0]           pos_wdata, pos_rdata;
    t_cmp_ctl                cmp_ctl;
    logic signed [SB-1:0]    cand;
    logic                    hit;

    logic                    in_ok;
    logic signed [SB-1:0]    smp_ext;
    logic signed [SMP_W-1:0] cand_w;
    logic [IW:0]             pos_inc;
    logic [IW-1:0]           pos_new;
    logic [IW-1:0]           len_last;

    // low SAMPLE_BITS of the field, sign from bit SAMPLE_BITS-1; a wider sample is zero-extended
    generate
        if (SB <= SMP_W) begin : g_in_narrow
            assign smp_ext = i_in.sample[SB-1:0];
        end else begin : g_in_wide
            assign smp_ext = {{(SB - SMP_W){1'b0}}, i_in.sample};
        end
        if (SB >= SMP_W) begin : g_out_narrow
            assign cand_w = cand[SMP_W-1:0];
        end else begin : g_out_wide
            assign cand_w = {{(SMP_W - SB){cand[SB-1]}}, cand};
        end
    endgenerate

    assign in_ok = ({1'b0, i_in.channel} < CH_LIM) && (i_in.window_len != '0)
                 && ({1'b0, i_in.window_len} < LEN_LIM);

    assign pos_inc  = {1'b0, pos_rdata} + 1'b1;
    assign pos_new  = (pos_inc >= {1'b0, r_len}) ? '0 : pos_inc[IW-1:0];
    assign len_last = r_len - 1'b1;

    always_comb begin
        n_state   = r_state;
        n_clr     = r_clr;
        n_base    = r_base;
        n_ch      = r_ch;
        n_len     = r_len;
        n_smp     = r_smp;
        n_i       = r_i;
        n_j       = r_j;
        n_med     = r_med;
        n_rej     = r_rej;
        mem_we    = 1'b0;
        mem_waddr = r_base + AW'(pos_new);
        mem_wdata = r_smp;
        mem_re    = 1'b0;
        mem_raddr = r_base + AW'(r_i);
        pos_we    = 1'b0;
        pos_waddr = r_ch;
        pos_wdata = pos_new;
        pos_re    = 1'b0;
        pos_raddr = i_in.channel[CW-1:0];
        cmp_ctl   = '0;

        case (r_state)
            S_CLR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr;
                mem_wdata = '0;
                pos_we    = ({1'b0, r_clr} < CHN_A);
                pos_waddr = r_clr[CW-1:0];
                pos_wdata = '0;
                n_clr     = r_clr + 1'b1;
                if (r_clr == CLR_LAST) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in.valid) begin
                    n_ch   = i_in.channel[CW-1:0];
                    n_base = AW'(i_in.channel[CW-1:0]) * WMAX_A;
                    n_len  = i_in.window_len[IW-1:0];
                    n_smp  = smp_ext;
                    if (in_ok) begin
                        pos_re  = 1'b1;
                        n_state = S_POS;
                    end else begin
                        n_med   = '0;
                        n_rej   = 1'b1;
                        n_state = S_FIN;
                    end
                end
            end
            S_POS: begin
                // advance position, store the new sample
                pos_we  = 1'b1;
                mem_we  = 1'b1;
                n_i     = '0;
                n_state = S_CRD;
            end
            S_CRD: begin
                mem_re  = 1'b1;
                n_state = S_CLD;
            end
            S_CLD: begin
                cmp_ctl.load = 1'b1;
                mem_re       = 1'b1;
                mem_raddr    = r_base;
                n_j          = '0;
                n_state      = S_SCAN;
            end
            S_SCAN: begin
                // data of entry r_j is on the read port now
                cmp_ctl.acc = 1'b1;
                if (r_j == len_last) begin
                    n_state = S_CHK;
                end else begin
                    mem_re    = 1'b1;
                    mem_raddr = r_base + AW'(r_j) + 1'b1;
                    n_j       = r_j + 1'b1;
                end
            end
            S_CHK: begin
                if (hit) begin
                    n_med   = cand_w;
                    n_rej   = 1'b0;
                    n_state = S_FIN;
                end else begin
                    n_i     = r_i + 1'b1;
                    n_state = S_CRD;
                end
            end
            S_FIN: begin
                if (!r_ov || o_out.ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // output register
    always_comb begin
        n_ov = r_ov;
        n_om = r_om;
        n_or = r_or;
        if (r_ov && o_out.ready) begin
            n_ov = 1'b0;
        end
        if ((r_state == S_FIN) && (!r_ov || o_out.ready)) begin
            n_ov = 1'b1;
            n_om = r_med;
            n_or = r_rej;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_clr   <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_base <= n_base;
        r_ch   <= n_ch;
        r_len  <= n_len;
        r_smp  <= n_smp;
        r_i    <= n_i;
        r_j    <= n_j;
        r_med  <= n_med;
        r_rej  <= n_rej;
        r_om   <= n_om;
        r_or   <= n_or;
    end

    msm_store #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .CHN   (CHANNELS),
        .CW    (CW),
        .IW    (IW),
        .SB    (SB)
    ) u_store (
        .i_clk       (i_clk),
        .i_we        (mem_we),
        .i_waddr     (mem_waddr),
        .i_wdata     (mem_wdata),
        .i_re        (mem_re),
        .i_raddr     (mem_raddr),
        .o_rdata     (mem_rdata),
        .i_pos_we    (pos_we),
        .i_pos_waddr (pos_waddr),
        .i_pos_wdata (pos_wdata),
        .i_pos_re    (pos_re),
        .i_pos_raddr (pos_raddr),
        .o_pos_rdata (pos_rdata)
    );

    msm_cmp #(
        .SB (SB),
        .IW (IW)
    ) u_cmp (
        .i_clk  (i_clk),
        .i_ctl  (cmp_ctl),
        .i_data (mem_rdata),
        .i_k    (r_len >> 1),
        .o_cand (cand),
        .o_hit  (hit)
    );

    assign i_in.ready     = (r_state == S_IDLE);
    assign o_out.valid    = r_ov;
    assign o_out.median   = r_om;
    assign o_out.rejected = r_or;

endmodule

`default_nettype wire

// File: rtl/msm_checker.sv
`default_nettype none

module msm_checker import msm_pkg::*; (
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    i_in_valid,
    input logic                    i_in_ready,
    input logic                    i_out_valid,
    input logic                    i_out_ready,
    input logic signed [SMP_W-1:0] i_out_median,
    input logic                    i_out_rejected
);

    // memories are being cleared right after reset
    a_busy_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_in_ready)
        else $error("ready high right after reset");

    // one word in work at a time
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("second word taken while one is in work");

    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_rejected) |-> (i_out_median == '0))
        else $error("rejected word with nonzero median");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> i_out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            ($stable(i_out_median) && $stable(i_out_rejected)))
        else $error("result changed while stalled");

endmodule

bind multichannel_sliding_median msm_checker u_msm_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in.valid),
    .i_in_ready     (i_in.ready),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_out_median   (o_out.median),
    .i_out_rejected (o_out.rejected)
);

`default_nettype wire
